### rtl/prc_pkg.sv
// package for the polygon rectangle clipper
// types, defaults and state codes for the top level and the testbench; no dependencies
package prc_pkg;

  localparam int MAX_IN_VERTS_DEF  = 16;
  localparam int MAX_OUT_VERTS_DEF = 64;
  localparam int COORD_BITS_DEF    = 16;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT  = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM = 2'd3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_START,
    ST_RD_FIRST,
    ST_RD_WAIT,
    ST_EDGE,
    ST_DIV,
    ST_PUT_CROSS,
    ST_PUT_V2,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SHOW,
    ST_EMPTY
  } state_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

endpackage

### rtl/prc_if.sv
// valid/ready channel interface carrying one vertex word
// depends on nothing; payload fields are plain logic vectors
interface prc_vertex_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex_x;
  logic [COORD_BITS-1:0] vertex_y;
  logic                  vertex_last;
  modport source(output valid, vertex_x, vertex_y, vertex_last, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_last, output ready);
endinterface

interface prc_result_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_last;
  logic                  poly_empty;
  logic                  store_overflow;
  modport source(output valid, out_x, out_y, out_last, poly_empty, store_overflow,
                 input ready);
  modport sink(input valid, out_x, out_y, out_last, poly_empty, store_overflow,
               output ready);
endinterface

### rtl/polygon_rect_clipper.sv
// polygon_rect_clipper: sutherland hodgman clip of a polygon to a rectangle
// depends on prc_pkg, prc_if, prc_ram, prc_div
//
//  channel | dir | handshake     | payload
//  vin     | in  | valid/ready   | vertex_x, vertex_y, vertex_last
//  vout    | out | valid/ready   | out_x, out_y, out_last, poly_empty, store_overflow
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// the last vertex starts four passes, one per side of the rectangle.
// each pass starts, then reads and tests each edge in turn; a crossing also waits
// for the one shared serial divider; the output reads each vertex from the store
// and shows it until it is taken.
// rst is synchronous and clears the sequencer, counts and flags.
// no vertex is taken while a polygon is clipped or emitted; output stalls hold.
module polygon_rect_clipper
  import prc_pkg::*;
#(
  parameter int MAX_IN_VERTS  = MAX_IN_VERTS_DEF,
  parameter int MAX_OUT_VERTS = MAX_OUT_VERTS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  prc_vertex_if.sink            vin,
  prc_result_if.source          vout
);
  localparam int CB  = COORD_BITS;
  localparam int AW  = $clog2(MAX_OUT_VERTS);
  localparam int IAW = $clog2(MAX_IN_VERTS);
  localparam int NW  = $clog2(MAX_OUT_VERTS + 1);
  localparam int NB  = 2 * (CB + 1);
  localparam int DB  = CB + 1;

  state_t state, state_next;

  logic signed [CB-1:0] clip_left, clip_bottom, clip_right, clip_top;
  logic [NW-1:0] cnt_in, cnt_src, cnt_dst, idx;
  logic          ovf;
  logic [1:0]    side;
  logic          cur_ab; // destination store: 1 a, 0 b

  // stores: input store plus two work stores
  logic          we_i, we_a, we_b;
  logic [AW-1:0] waddr;
  logic [IAW-1:0] waddr_i;
  logic [2*CB-1:0] wdata, rd_i, rd_a, rd_b, rd;
  logic [AW-1:0] raddr;

  prc_ram #(.WIDTH(2*CB), .DEPTH(MAX_IN_VERTS)) u_in (
    .clk, .we(we_i), .waddr(waddr_i), .wdata, .raddr(raddr[IAW-1:0]), .rdata(rd_i));
  prc_ram #(.WIDTH(2*CB), .DEPTH(MAX_OUT_VERTS)) u_a (
    .clk, .we(we_a), .waddr, .wdata, .raddr, .rdata(rd_a));
  prc_ram #(.WIDTH(2*CB), .DEPTH(MAX_OUT_VERTS)) u_b (
    .clk, .we(we_b), .waddr, .wdata, .raddr, .rdata(rd_b));

  // pass p reads: left from input, top from a, right from b, bottom from a
  always_comb begin
    case (side)
      SIDE_LEFT:  rd = rd_i;
      SIDE_TOP:   rd = rd_a;
      SIDE_RIGHT: rd = rd_b;
      default:    rd = rd_a;
    endcase
  end
  assign cur_ab = (side == SIDE_LEFT) || (side == SIDE_RIGHT); // dst is a

  logic signed [CB-1:0] x1, y1, x2, y2, bnd, v0x, v0y;
  logic in1, in2, vert;

  function automatic logic is_in(input logic [1:0] s, input logic signed [CB-1:0] x,
                                 input logic signed [CB-1:0] y,
                                 input logic signed [CB-1:0] b);
    case (s)
      SIDE_LEFT:  return x >= b;
      SIDE_TOP:   return y <= b;
      SIDE_RIGHT: return x <= b;
      default:    return y >= b;
    endcase
  endfunction

  always_comb begin
    case (side)
      SIDE_LEFT:  bnd = clip_left;
      SIDE_TOP:   bnd = clip_top;
      SIDE_RIGHT: bnd = clip_right;
      default:    bnd = clip_bottom;
    endcase
  end
  assign vert = (side == SIDE_LEFT) || (side == SIDE_RIGHT);
  assign in1  = is_in(side, x1, y1, bnd);
  assign in2  = is_in(side, x2, y2, bnd);

  // crossing operands
  logic signed [CB-1:0] a1, c1, a2, c2;
  logic signed [CB:0]   dc, tt, dd;
  logic [CB:0]          mdc, mtt, mdd;
  logic                 neg, neg_r;
  logic [NB-1:0]        num_w, quo;
  logic [DB-1:0]        den_w;
  logic                 div_done;
  logic signed [CB-1:0] c1_r, cross_v;
  div_ctrl_t            dctl;

  assign a1 = vert ? x1 : y1;
  assign c1 = vert ? y1 : x1;
  assign a2 = vert ? x2 : y2;
  assign c2 = vert ? y2 : x2;
  assign dc = {c2[CB-1], c2} - {c1[CB-1], c1};
  assign tt = {bnd[CB-1], bnd} - {a1[CB-1], a1};
  assign dd = {a2[CB-1], a2} - {a1[CB-1], a1};
  assign mdc = dc[CB] ? -dc : dc;
  assign mtt = tt[CB] ? -tt : tt;
  assign mdd = dd[CB] ? -dd : dd;
  assign neg = (dc[CB] ^ tt[CB]) ^ dd[CB];
  assign num_w = NB'(mdc * mtt);
  assign den_w = mdd;

  prc_div #(.NB(NB), .DB(DB)) u_div (
    .clk, .rst, .start(dctl.start), .num(num_w), .den(den_w),
    .done(div_done), .quo);

  assign cross_v = neg_r ? c1_r - CB'(quo) : c1_r + CB'(quo);

  // result register
  logic [CB-1:0] ox, oy;
  logic          olast, oempty, oovf, ovalid;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:       if (vin.valid && vin.vertex_last) state_next = ST_PASS_START;
      ST_PASS_START: state_next = (cnt_src == '0) ? ST_NEXT : ST_RD_FIRST;
      ST_RD_FIRST:   state_next = ST_RD_WAIT;
      ST_RD_WAIT:    state_next = ST_EDGE;
      ST_EDGE: begin
        if (in1 != in2)  state_next = ST_DIV;
        else if (in2)    state_next = ST_PUT_V2;
        else             state_next = ST_NEXT;
      end
      ST_DIV:        if (div_done) state_next = ST_PUT_CROSS;
      ST_PUT_CROSS:  state_next = in2 ? ST_PUT_V2 : ST_NEXT;
      ST_PUT_V2:     state_next = ST_NEXT;
      ST_NEXT: begin
        if (idx != '0)                  state_next = ST_RD_WAIT;
        else if (side != SIDE_BOTTOM)   state_next = ST_PASS_START;
        else if (cnt_dst == '0)         state_next = ST_EMPTY;
        else                            state_next = ST_OUT_RD;
      end
      ST_OUT_RD:     state_next = ST_OUT_WAIT;
      ST_OUT_WAIT:   state_next = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (vout.ready) state_next = (idx == cnt_dst) ? ST_LOAD : ST_OUT_RD;
      end
      ST_EMPTY:      if (vout.ready && ovalid) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    vin.ready  = (state == ST_LOAD);
    dctl.start = (state == ST_EDGE) && (in1 != in2);
    we_i    = (state == ST_LOAD) && vin.valid && (cnt_in < NW'(MAX_IN_VERTS));
    waddr_i = cnt_in[IAW-1:0];
    waddr   = cnt_dst[AW-1:0];
    wdata   = {x2, y2};
    if (state == ST_LOAD) begin
      wdata = {vin.vertex_x, vin.vertex_y};
    end else if (state == ST_PUT_CROSS) begin
      wdata = vert ? {bnd, cross_v} : {cross_v, bnd};
    end
    we_a = 1'b0;
    we_b = 1'b0;
    if (((state == ST_PUT_CROSS) || (state == ST_PUT_V2))
        && (cnt_dst < NW'(MAX_OUT_VERTS))) begin
      we_a = cur_ab;
      we_b = !cur_ab;
    end
    raddr = idx[AW-1:0];
    vout.valid          = ovalid;
    vout.out_x          = ox;
    vout.out_y          = oy;
    vout.out_last       = olast;
    vout.poly_empty     = oempty;
    vout.store_overflow = oovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      clip_left   <= '0;
      clip_bottom <= '0;
      clip_right  <= {1'b0, {(CB-1){1'b1}}};
      clip_top    <= {1'b0, {(CB-1){1'b1}}};
      cnt_in      <= '0;
      ovf         <= 1'b0;
      ovalid      <= 1'b0;
      side        <= SIDE_LEFT;
      idx         <= '0;
      cnt_src     <= '0;
      cnt_dst     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:   clip_left   <= cfg_data;
          REG_BOTTOM: clip_bottom <= cfg_data;
          REG_RIGHT:  clip_right  <= cfg_data;
          REG_TOP:    clip_top    <= cfg_data;
          default:    ;
        endcase
      end
      case (state)
        ST_LOAD: begin
          if (vin.valid) begin
            if (cnt_in < NW'(MAX_IN_VERTS)) cnt_in <= cnt_in + 1'b1;
            else                            ovf <= 1'b1;
            if (vin.vertex_last) begin
              side    <= SIDE_LEFT;
              cnt_src <= (cnt_in < NW'(MAX_IN_VERTS)) ? cnt_in + 1'b1 : cnt_in;
              cnt_dst <= '0;
              idx     <= '0;
            end
          end
        end
        ST_PASS_START: idx <= (cnt_src == '0) ? '0 : NW'(1);
        ST_RD_FIRST: begin
          x1  <= rd[2*CB-1:CB];
          y1  <= rd[CB-1:0];
          v0x <= rd[2*CB-1:CB];
          v0y <= rd[CB-1:0];
        end
        ST_RD_WAIT: begin
          // idx indexes the current edge end; wraps to the first vertex
          if (idx == cnt_src || idx == '0) begin
            x2 <= v0x;
            y2 <= v0y;
          end else begin
            x2 <= rd[2*CB-1:CB];
            y2 <= rd[CB-1:0];
          end
          idx <= (idx == cnt_src) ? '0 : idx + 1'b1;
        end
        ST_EDGE: begin
          neg_r <= neg;
          c1_r  <= c1;
        end
        ST_PUT_CROSS, ST_PUT_V2: begin
          if (cnt_dst < NW'(MAX_OUT_VERTS)) cnt_dst <= cnt_dst + 1'b1;
          else                              ovf <= 1'b1;
        end
        ST_NEXT: begin
          x1 <= x2;
          y1 <= y2;
          if (idx == '0) begin
            if (side != SIDE_BOTTOM) begin
              side    <= side + 1'b1;
              cnt_src <= cnt_dst;
              cnt_dst <= '0;
              idx     <= '0;
            end else begin
              idx <= '0;
            end
          end
        end
        ST_OUT_WAIT: begin
          ox     <= rd_b[2*CB-1:CB];
          oy     <= rd_b[CB-1:0];
          olast  <= (idx + 1'b1 == cnt_dst);
          oempty <= 1'b0;
          oovf   <= ovf;
          ovalid <= 1'b1;
          idx    <= idx + 1'b1;
        end
        ST_OUT_SHOW: begin
          if (vout.ready) begin
            ovalid <= 1'b0;
            if (idx == cnt_dst) begin
              cnt_in <= '0;
              ovf    <= 1'b0;
            end
          end
        end
        ST_EMPTY: begin
          if (!ovalid) begin
            ox     <= '0;
            oy     <= '0;
            olast  <= 1'b1;
            oempty <= 1'b1;
            oovf   <= ovf;
            ovalid <= 1'b1;
          end else if (vout.ready) begin
            ovalid <= 1'b0;
            cnt_in <= '0;
            ovf    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/prc_ram.sv
// generic single port write, single port read ram with registered read
// depends on nothing
module prc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/prc_div.sv
// restoring unsigned divider, one quotient bit per cycle, rounds to nearest
// depends on nothing; used for the boundary crossing quotient
module prc_div #(
  parameter int NB = 34,
  parameter int DB = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic          done,
  output logic [NB-1:0] quo
);
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] q;
  logic [DB:0]   rem;
  logic [DB-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DB:0]   shifted;
  logic [DB+1:0] twice;

  assign shifted = {rem[DB-1:0], q[NB-1]};
  assign twice   = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CW'(NB);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          // round half up on the magnitude
          quo  <= (twice >= {2'b0, d}) ? q + 1'b1 : q;
        end else begin
          cnt <= cnt - 1'b1;
          if (shifted >= {1'b0, d}) begin
            rem <= shifted - {1'b0, d};
            q   <= {q[NB-2:0], 1'b1};
          end else begin
            rem <= shifted;
            q   <= {q[NB-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

### rtl/prc_checker.sv
// port level checker for polygon_rect_clipper, bound to the top level
// depends on prc_if through the bound top level ports
module prc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic poly_empty,
  input logic [15:0] out_x
);
  // no vertex is taken while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready while result pending");
  // an empty result is marked last
  a_empty: assert property (@(posedge clk) disable iff (rst) (out_valid && poly_empty)
    |-> out_last) else $error("empty result not last");
  a_empty0: assert property (@(posedge clk) disable iff (rst) (out_valid && poly_empty)
    |-> out_x == '0) else $error("empty result nonzero");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready)
    |=> out_valid) else $error("result dropped");
endmodule

bind polygon_rect_clipper prc_checker u_prc_checker (
  .clk(clk), .rst(rst), .in_ready(vin.ready),
  .out_valid(vout.valid), .out_ready(vout.ready), .out_last(vout.out_last),
  .poly_empty(vout.poly_empty), .out_x(vout.out_x[15:0]));

### tb/tb_top.sv
// testbench for polygon_rect_clipper: loads polygons, predicts the clipped vertex list
// depends on prc_pkg and the prc_vertex_if / prc_result_if interfaces in rtl
module tb_top
  import prc_pkg::*;
();

  localparam int NIN = 16;
  localparam int NOUT = 64;
  localparam int WATCH_LIMIT = 200000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic last;
    logic empty;
    logic ovf;
  } clip_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LEFT;
  logic [15:0] cfg_data = '0;

  prc_vertex_if #(16) vin ();
  prc_result_if #(16) vout ();

  polygon_rect_clipper dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .vin(vin.sink), .vout(vout.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  longint win_left, win_bottom, win_right, win_top;
  longint poly_x[$], poly_y[$];
  bit poly_ovf;
  clip_word_t clip_expected[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint crossing(longint a1, longint c1, longint a2, longint c2,
                                      longint b);
    longint dc, t, d, num, den, q, r;
    bit neg;
    dc = c2 - c1; t = b - a1; d = a2 - a1;
    neg = ((dc < 0) != (t < 0)) != (d < 0);
    num = (dc < 0 ? -dc : dc) * (t < 0 ? -t : t);
    den = d < 0 ? -d : d;
    if (den == 0 || num == 0) return c1;
    q = num / den; r = num % den;
    if (r >= den - r) q++;
    return neg ? c1 - q : c1 + q;
  endfunction

  function automatic bit in_window(int side, longint x, longint y, longint b);
    case (side)
      0: return x >= b;
      1: return y <= b;
      2: return x <= b;
      default: return y >= b;
    endcase
  endfunction

  task automatic clip_side(ref longint sx[$], ref longint sy[$], input int side,
                           input longint b);
    longint dx[$], dy[$];
    longint x1, y1, x2, y2;
    int j;
    bit in1, in2;
    for (int i = 0; i < sx.size() && i < NOUT; i++) begin
      j = (i + 1 < sx.size()) ? i + 1 : 0;
      x1 = sx[i]; y1 = sy[i]; x2 = sx[j]; y2 = sy[j];
      in1 = in_window(side, x1, y1, b);
      in2 = in_window(side, x2, y2, b);
      if (in1 != in2) begin
        if (dx.size() >= NOUT) poly_ovf = 1;
        else if (side == 0 || side == 2) begin
          dx.push_back(b); dy.push_back(crossing(x1, y1, x2, y2, b));
        end else begin
          dx.push_back(crossing(y1, x1, y2, x2, b)); dy.push_back(b);
        end
      end
      if (in2) begin
        if (dx.size() >= NOUT) poly_ovf = 1;
        else begin
          dx.push_back(x2); dy.push_back(y2);
        end
      end
    end
    sx = dx; sy = dy;
  endtask

  task automatic predict_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                                input bit last);
    longint px[$], py[$];
    clip_word_t w;
    if (poly_x.size() < NIN) begin
      poly_x.push_back(longint'(x)); poly_y.push_back(longint'(y));
    end else poly_ovf = 1;
    if (!last) return;
    px = poly_x; py = poly_y;
    clip_side(px, py, 0, win_left);
    clip_side(px, py, 1, win_top);
    clip_side(px, py, 2, win_right);
    clip_side(px, py, 3, win_bottom);
    if (px.size() == 0) begin
      w.x = '0; w.y = '0; w.last = 1; w.empty = 1; w.ovf = poly_ovf;
      clip_expected.push_back(w);
    end else begin
      for (int i = 0; i < px.size(); i++) begin
        w.x = 16'(px[i]); w.y = 16'(py[i]); w.last = (i == px.size() - 1); w.empty = 0;
        w.ovf = poly_ovf;
        clip_expected.push_back(w);
      end
    end
    poly_x.delete(); poly_y.delete(); poly_ovf = 0;
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;

  initial begin
    vin.valid = 1'b0; vin.vertex_x = '0; vin.vertex_y = '0; vin.vertex_last = 1'b0;
  end

  task automatic send_vertex(input int x, input int y, input int last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    vin.valid <= 1'b1; vin.vertex_x <= 16'(x); vin.vertex_y <= 16'(y);
    vin.vertex_last <= (last != 0);
    predict_vertex(16'(x), 16'(y), last != 0);
    do @(posedge clk); while (!vin.ready);
  endtask

  task automatic wait_drained;
    vin.valid <= 1'b0;
    while (clip_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(input longint l, input longint b, input longint r,
                              input longint t);
    longint vals[4];
    logic [1:0] idx[4];
    vals = '{l, b, r, t};
    idx = '{REG_LEFT, REG_BOTTOM, REG_RIGHT, REG_TOP};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1; cfg_index <= idx[i]; cfg_data <= vals[i][15:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    win_left = l; win_bottom = b; win_right = r; win_top = t;
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    clip_word_t w;
    if (rst) begin
      vout.ready <= 1'b0;
    end else begin
      if (vout.valid && vout.ready) begin
        if (clip_expected.size() == 0) begin
          $display("unexpected word at %0t", $time);
          errors++;
        end else begin
          w = clip_expected.pop_front();
          if (vout.out_x !== w.x)
            report("out_x", longint'($signed(vout.out_x)), longint'(w.x));
          if (vout.out_y !== w.y)
            report("out_y", longint'($signed(vout.out_y)), longint'(w.y));
          if (vout.out_last !== w.last)
            report("out_last", longint'(vout.out_last), longint'(w.last));
          if (vout.poly_empty !== w.empty)
            report("poly_empty", longint'(vout.poly_empty), longint'(w.empty));
          if (vout.store_overflow !== w.ovf)
            report("store_overflow", longint'(vout.store_overflow), longint'(w.ovf));
        end
      end
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: vout.ready <= 1'b1;
        1: vout.ready <= ($urandom_range(0, 3) != 0);
        default: vout.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int rand_coord(input int mode);
    case (mode)
      0: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 1200)) - 400;
    endcase
  endfunction

  task automatic random_polygon(input int nverts, input int mode);
    for (int i = 0; i < nverts; i++)
      send_vertex(rand_coord(mode), rand_coord(mode), (i == nverts - 1) ? 1 : 0);
  endtask

  task automatic test_directed;
    write_window(0, 0, 512, 512);
    // square crossing every side
    send_vertex(-100, -100, 0); send_vertex(700, -100, 0);
    send_vertex(700, 700, 0);   send_vertex(-100, 700, 1);
    // wholly outside
    send_vertex(-300, 10, 0); send_vertex(-200, 20, 0); send_vertex(-250, 90, 1);
    // single vertex and two vertices
    send_vertex(100, 100, 1);
    send_vertex(512, 0, 0); send_vertex(600, 300, 1);
    // vertex on right boundary
    send_vertex(512, 100, 0); send_vertex(100, 100, 0); send_vertex(512, 400, 1);
    // field extremes
    send_vertex(16'h8000, 16'h7fff, 0); send_vertex(16'h7fff, 16'h8000, 0);
    send_vertex(16'hffff, 16'h0000, 1);
  endtask

  task automatic test_input_overflow;
    random_polygon(20, 1);
    random_polygon(17, 1);
  endtask

  task automatic test_window_extremes;
    write_window(-32768, -32768, 32767, 32767);
    random_polygon(6, 0);
    random_polygon(4, 0);
    write_window(32767, 32767, -32768, -32768);
    random_polygon(5, 1);
    write_window(200, 200, 200, 200);
    random_polygon(5, 1);
  endtask

  task automatic test_random;
    int sent;
    sent = 0;
    while (sent < 400) begin
      int n;
      if (sent % 80 == 0)
        write_window(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                     int'($urandom_range(0, 800)), int'($urandom_range(0, 800)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : $urandom_range(3, 10);
      random_polygon(n, $urandom_range(0, 5) == 0 ? 0 : 1);
      sent += n;
    end
  endtask

  initial begin
    win_left = 0; win_bottom = 0; win_right = 32767; win_top = 32767; poly_ovf = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_input_overflow();
    test_window_extremes();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && clip_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
